>>> rtl/cau_pkg.sv
// Shared command and status codes of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int CMD_W = 3;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIST = 3'd4;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/complex_arithmetic_unit_top.sv
// Pipelined complex-number ALU: add, subtract, multiply, divide and distance.
//
//  channel   dir  tdata (low bit up)                     tuser
//  --------  ---  -------------------------------------  -------------
//  s_axis    in   p_re, p_im, q_re, q_im (zero padded)   command
//  m_axis    out  res_re, res_im (zero padded)           status
//
// One word enters per cycle while m_axis is not stalled. The pipe has four
// front stages (operands, sums and differences, products, combined
// products), one setup stage, DATA_WIDTH + 1 stages of the shared restoring
// divide and square-root steps and one rounding stage.
// All stages advance together whenever the output register is empty or
// taken; a stall on m_axis freezes the whole pipe, nothing is lost.
// Reset (synchronous, active low) clears only the valid bits.
`default_nettype none

module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // p_re, p_im, q_re, q_im
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [cau_pkg::CMD_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // res_re, res_im
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [cau_pkg::ST_W-1:0] m_axis_tuser
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int ODW  = ((2*DATA_WIDTH+7)/8)*8;
    localparam int PW   = 2*W;          // operand product
    localparam int NUMW = 2*W + 1;      // sum of two products
    localparam int SW   = 2*W + 2;      // sum of squares
    localparam int CW   = 3*W + F + 2;  // divider / root working width
    localparam int QW   = W + 1;        // quotient and root
    localparam int NIT  = W + 1;        // step stages

    localparam logic [CW-1:0] RND =
        (F > 0) ? (CW'(1) << ((F > 0) ? F - 1 : 0)) : '0;
    localparam logic [CW-1:0] POS_MAX = (CW'(1) << (W - 1)) - CW'(1);
    localparam logic [CW-1:0] NEG_MAG = CW'(1) << (W - 1);

    // Clamp a sign/magnitude value into W bits; top bit returns saturation.
    function automatic logic [W:0] f_clamp(input logic neg, input logic [CW-1:0] mag);
        logic          sat;
        logic [W-1:0]  val;
        sat = 1'b0;
        if (neg) begin
            if (mag > NEG_MAG) begin
                sat = 1'b1;
                val = {1'b1, {(W-1){1'b0}}};
            end else begin
                val = W'(CW'(0) - mag);
            end
        end else begin
            if (mag > POS_MAX) begin
                sat = 1'b1;
                val = {1'b0, {(W-1){1'b1}}};
            end else begin
                val = mag[W-1:0];
            end
        end
        return {sat, val};
    endfunction

    typedef struct packed {
        logic [cau_pkg::CMD_W-1:0] cmd;
        logic [W-1:0]  res_re;
        logic [W-1:0]  res_im;
        logic          sat;
        logic          dz;
        logic          sgn_re;
        logic          sgn_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [SW-1:0] den;
        logic [CW-1:0] r_re;
        logic [CW-1:0] r_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
        logic [CW-1:0] rem;
        logic [QW-1:0] root;
    } t_it;

    logic adv;

    // ---------------- stage A: operand register
    logic                        r_a_vld;
    logic [cau_pkg::CMD_W-1:0]   r_a_cmd;
    logic signed [W-1:0]         r_a_a, r_a_b, r_a_c, r_a_d;

    // ---------------- stage B: sums, differences, square operands
    logic                        r_b_vld;
    logic [cau_pkg::CMD_W-1:0]   r_b_cmd;
    logic signed [W-1:0]         r_b_a, r_b_b, r_b_c, r_b_d;
    logic signed [W:0]           r_b_sa, r_b_sb;
    logic [W-1:0]                r_b_re, r_b_im;
    logic                        r_b_sat;
    logic signed [W:0]           n_b_sre, n_b_sim, n_b_dr, n_b_di;
    logic [W-1:0]                n_b_re, n_b_im;
    logic                        n_b_sat;

    // ---------------- stage C: products
    logic                        r_c_vld;
    logic [cau_pkg::CMD_W-1:0]   r_c_cmd;
    logic signed [PW-1:0]        r_c_ac, r_c_bd, r_c_ad, r_c_bc;
    logic [SW-1:0]               r_c_sa2, r_c_sb2;
    logic [W-1:0]                r_c_re, r_c_im;
    logic                        r_c_sat;

    // ---------------- stage D: combined products
    logic                        r_d_vld;
    logic [cau_pkg::CMD_W-1:0]   r_d_cmd;
    logic signed [NUMW-1:0]      r_d_num_re, r_d_num_im;
    logic [SW-1:0]               r_d_sum;
    logic [W-1:0]                r_d_re, r_d_im;
    logic                        r_d_sat;
    logic signed [NUMW-1:0]      n_d_num_re, n_d_num_im;

    // ---------------- step stages
    logic [NIT:0]                r_it_vld;
    t_it                         r_it [0:NIT];
    t_it                         n_it0;

    // ---------------- output register
    logic                        r_o_vld;
    logic [W-1:0]                r_o_re, r_o_im;
    logic [cau_pkg::ST_W-1:0]    r_o_st;
    logic [W-1:0]                n_o_re, n_o_im;
    logic [cau_pkg::ST_W-1:0]    n_o_st;

    // Advance the whole pipe when the output slot is free or being taken.
    assign adv           = !r_o_vld || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_it_vld <= '0;
            r_o_vld  <= 1'b0;
        end else if (adv) begin
            r_a_vld  <= s_axis_tvalid;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_d_vld  <= r_c_vld;
            r_it_vld <= {r_it_vld[NIT-1:0], r_d_vld};
            r_o_vld  <= r_it_vld[NIT];
        end
    end

    // ---------------- stage A
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_cmd <= s_axis_tuser;
            r_a_a   <= $signed(s_axis_tdata[W-1:0]);
            r_a_b   <= $signed(s_axis_tdata[2*W-1:W]);
            r_a_c   <= $signed(s_axis_tdata[3*W-1:2*W]);
            r_a_d   <= $signed(s_axis_tdata[4*W-1:3*W]);
        end
    end

    // ---------------- stage B: add/subtract finish here, saturate on sign split
    always_comb begin
        logic sat_re, sat_im;
        n_b_dr  = {r_a_a[W-1], r_a_a} - {r_a_c[W-1], r_a_c};
        n_b_di  = {r_a_b[W-1], r_a_b} - {r_a_d[W-1], r_a_d};
        if (r_a_cmd == cau_pkg::CMD_SUB) begin
            n_b_sre = n_b_dr;
            n_b_sim = n_b_di;
        end else begin
            n_b_sre = {r_a_a[W-1], r_a_a} + {r_a_c[W-1], r_a_c};
            n_b_sim = {r_a_b[W-1], r_a_b} + {r_a_d[W-1], r_a_d};
        end
        sat_re = n_b_sre[W] ^ n_b_sre[W-1];
        sat_im = n_b_sim[W] ^ n_b_sim[W-1];
        n_b_re = sat_re ? {n_b_sre[W], {(W-1){~n_b_sre[W]}}} : n_b_sre[W-1:0];
        n_b_im = sat_im ? {n_b_sim[W], {(W-1){~n_b_sim[W]}}} : n_b_sim[W-1:0];
        n_b_sat = sat_re || sat_im;
        if (r_a_cmd != cau_pkg::CMD_ADD && r_a_cmd != cau_pkg::CMD_SUB) begin
            n_b_re  = '0;
            n_b_im  = '0;
            n_b_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_cmd <= r_a_cmd;
            r_b_a   <= r_a_a;
            r_b_b   <= r_a_b;
            r_b_c   <= r_a_c;
            r_b_d   <= r_a_d;
            // distance squares the difference, divide squares q
            r_b_sa  <= (r_a_cmd == cau_pkg::CMD_DIST) ? n_b_dr : {r_a_c[W-1], r_a_c};
            r_b_sb  <= (r_a_cmd == cau_pkg::CMD_DIST) ? n_b_di : {r_a_d[W-1], r_a_d};
            r_b_re  <= n_b_re;
            r_b_im  <= n_b_im;
            r_b_sat <= n_b_sat;
        end
    end

    // ---------------- stage C: six independent multipliers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_cmd <= r_b_cmd;
            r_c_ac  <= r_b_a * r_b_c;
            r_c_bd  <= r_b_b * r_b_d;
            r_c_ad  <= r_b_a * r_b_d;
            r_c_bc  <= r_b_b * r_b_c;
            r_c_sa2 <= SW'(r_b_sa) * SW'(r_b_sa);
            r_c_sb2 <= SW'(r_b_sb) * SW'(r_b_sb);
            r_c_re  <= r_b_re;
            r_c_im  <= r_b_im;
            r_c_sat <= r_b_sat;
        end
    end

    // ---------------- stage D
    always_comb begin
        if (r_c_cmd == cau_pkg::CMD_MUL) begin
            n_d_num_re = NUMW'(r_c_ac) - NUMW'(r_c_bd);
            n_d_num_im = NUMW'(r_c_ad) + NUMW'(r_c_bc);
        end else begin
            n_d_num_re = NUMW'(r_c_ac) + NUMW'(r_c_bd);
            n_d_num_im = NUMW'(r_c_bc) - NUMW'(r_c_ad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_cmd    <= r_c_cmd;
            r_d_num_re <= n_d_num_re;
            r_d_num_im <= n_d_num_im;
            r_d_sum    <= r_c_sa2 + r_c_sb2;
            r_d_re     <= r_c_re;
            r_d_im     <= r_c_im;
            r_d_sat    <= r_c_sat;
        end
    end

    // ---------------- setup: narrow products, load divider and root
    always_comb begin
        logic [CW-1:0] mre, mim, nre, nim, dsh;
        logic [W:0]    cre, cim;
        mre = CW'(r_d_num_re[NUMW-1] ? -r_d_num_re : r_d_num_re);
        mim = CW'(r_d_num_im[NUMW-1] ? -r_d_num_im : r_d_num_im);
        nre = (mre + RND) >> F;
        nim = (mim + RND) >> F;
        cre = f_clamp(r_d_num_re[NUMW-1], nre);
        cim = f_clamp(r_d_num_im[NUMW-1], nim);
        dsh = CW'(r_d_sum) << W;

        n_it0        = '0;
        n_it0.cmd    = r_d_cmd;
        n_it0.res_re = r_d_re;
        n_it0.res_im = r_d_im;
        n_it0.sat    = r_d_sat;
        n_it0.den    = r_d_sum;
        n_it0.sgn_re = r_d_num_re[NUMW-1];
        n_it0.sgn_im = r_d_num_im[NUMW-1];
        n_it0.r_re   = mre << F;
        n_it0.r_im   = mim << F;
        n_it0.ovf_re = (mre << F) >= dsh;
        n_it0.ovf_im = (mim << F) >= dsh;
        n_it0.dz     = (r_d_cmd == cau_pkg::CMD_DIV) && (r_d_sum == '0);
        n_it0.rem    = CW'(r_d_sum);
        if (r_d_cmd == cau_pkg::CMD_MUL) begin
            n_it0.res_re = cre[W-1:0];
            n_it0.res_im = cim[W-1:0];
            n_it0.sat    = cre[W] || cim[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it[0] <= n_it0;
        end
    end

    // ---------------- step stages: one quotient bit and one root bit each
    for (genvar j = 0; j < NIT; j++) begin : g_it
        // quotient bit of this stage; the last stage only finishes the root
        localparam int QB = (j < W) ? W - 1 - j : 0;
        t_it n_it;
        always_comb begin
            logic [CW-1:0] t;
            n_it = r_it[j];
            t    = (CW'(r_it[j].root) << (W - j + 1)) + (CW'(1) << (2 * (W - j)));
            if (r_it[j].rem >= t) begin
                n_it.rem        = r_it[j].rem - t;
                n_it.root[W-j]  = 1'b1;
            end
            if (j < W) begin
                if (r_it[j].r_re >= (CW'(r_it[j].den) << QB)) begin
                    n_it.r_re     = r_it[j].r_re - (CW'(r_it[j].den) << QB);
                    n_it.q_re[QB] = 1'b1;
                end
                if (r_it[j].r_im >= (CW'(r_it[j].den) << QB)) begin
                    n_it.r_im     = r_it[j].r_im - (CW'(r_it[j].den) << QB);
                    n_it.q_im[QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_it[j+1] <= n_it;
            end
        end
    end

    // ---------------- rounding, clamp and status
    always_comb begin
        t_it           s;
        logic [QW-1:0] qre, qim, rt;
        logic [CW-1:0] mre, mim;
        logic [W:0]    cre, cim, cs;
        logic          sat;
        s   = r_it[NIT];
        qre = s.q_re + QW'((s.r_re << 1) >= CW'(s.den));
        qim = s.q_im + QW'((s.r_im << 1) >= CW'(s.den));
        mre = s.ovf_re ? '1 : CW'(qre);
        mim = s.ovf_im ? '1 : CW'(qim);
        cre = f_clamp(s.sgn_re && (mre != '0), mre);
        cim = f_clamp(s.sgn_im && (mim != '0), mim);
        rt  = s.root + QW'(s.rem > CW'(s.root));
        cs  = f_clamp(1'b0, CW'(rt));

        n_o_re = s.res_re;
        n_o_im = s.res_im;
        sat    = s.sat;
        unique case (s.cmd)
            cau_pkg::CMD_DIV: begin
                n_o_re = cre[W-1:0];
                n_o_im = cim[W-1:0];
                sat    = cre[W] || cim[W];
            end
            cau_pkg::CMD_DIST: begin
                n_o_re = cs[W-1:0];
                n_o_im = '0;
                sat    = cs[W];
            end
            default: begin
            end
        endcase

        if (s.dz) begin
            n_o_re = '0;
            n_o_im = '0;
            n_o_st = cau_pkg::ST_DZ;
        end else if (sat) begin
            n_o_st = cau_pkg::ST_SAT;
        end else begin
            n_o_st = cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_re <= n_o_re;
            r_o_im <= n_o_im;
            r_o_st <= n_o_st;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = ODW'({r_o_im, r_o_re});
    assign m_axis_tuser  = r_o_st;

endmodule

`default_nettype wire

>>> rtl/cau_checker.sv
// Port-level checks of the complex arithmetic unit, bound to the top level.
`default_nettype none

module cau_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input wire logic [cau_pkg::ST_W-1:0] m_axis_tuser
);

    // Drop all results out of reset.
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An empty output slot never backs up the input.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Divide by zero returns zero in both parts.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == cau_pkg::ST_DZ) |-> (m_axis_tdata == '0))
        else $error("divide by zero with nonzero data");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
// Testbench for the complex arithmetic unit: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int LATENCY = DW + 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DW-1:0]   res_re;
        logic [DW-1:0]   res_im;
        logic [cau_pkg::ST_W-1:0] status;
    } t_cplx_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [4*DW-1:0] s_axis_tdata = '0;            // p_re, p_im, q_re, q_im
    logic [cau_pkg::CMD_W-1:0] s_axis_tuser = '0;  // command
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [2*DW-1:0] m_axis_tdata;                 // res_re, res_im
    logic [cau_pkg::ST_W-1:0] m_axis_tuser;        // status

    t_cplx_result result_queue[$];
    int  error_count = 0;
    longint cycle_count = 0;
    bit  no_idle = 1'b0;      // long stretch with no idling on either side
    int  hold_off = 0;        // receiver hold-off, counted in cycles

    complex_arithmetic_unit_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Clamp sign/magnitude to the signed output range; flag saturation.
    function automatic logic [DW-1:0] clamp_part(input bit neg, input longint unsigned mag,
                                                 inout bit sat);
        longint unsigned pos_max, neg_mag;
        pos_max = (64'd1 << (DW-1)) - 1;
        neg_mag = 64'd1 << (DW-1);
        if (neg) begin
            if (mag > neg_mag) begin
                sat = 1'b1;
                mag = neg_mag;
            end
            return DW'(-mag);
        end
        if (mag > pos_max) begin
            sat = 1'b1;
            mag = pos_max;
        end
        return DW'(mag);
    endfunction

    function automatic longint unsigned abs_val(input longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    // Drop FB fraction bits of a product, rounding ties away from zero.
    function automatic logic [DW-1:0] round_product(input longint x, inout bit sat);
        longint unsigned m;
        m = abs_val(x);
        if (FB > 0) m = (m + (64'd1 << (FB-1))) >> FB;
        return clamp_part(x < 0, m, sat);
    endfunction

    function automatic logic [DW-1:0] divide_part(input longint num, input longint unsigned den,
                                                  inout bit sat);
        longint unsigned m, qv;
        m = abs_val(num) << FB;
        qv = (2*m + den) / (2*den);
        return clamp_part(num < 0 && qv != 0, qv, sat);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_cplx_result predict_result(input logic [cau_pkg::CMD_W-1:0] cmd,
                                                    input logic [4*DW-1:0] ops);
        longint a, b, c, d, dr, di;
        longint unsigned den, sq, s;
        bit sat;
        t_cplx_result r;
        a = longint'($signed(ops[DW-1:0]));
        b = longint'($signed(ops[2*DW-1:DW]));
        c = longint'($signed(ops[3*DW-1:2*DW]));
        d = longint'($signed(ops[4*DW-1:3*DW]));
        sat = 1'b0;
        r = '0;
        r.status = cau_pkg::ST_OK;
        case (cmd)
            cau_pkg::CMD_ADD: begin
                r.res_re = clamp_part(a + c < 0, abs_val(a + c), sat);
                r.res_im = clamp_part(b + d < 0, abs_val(b + d), sat);
            end
            cau_pkg::CMD_SUB: begin
                r.res_re = clamp_part(a - c < 0, abs_val(a - c), sat);
                r.res_im = clamp_part(b - d < 0, abs_val(b - d), sat);
            end
            cau_pkg::CMD_MUL: begin
                r.res_re = round_product(a*c - b*d, sat);
                r.res_im = round_product(a*d + b*c, sat);
            end
            cau_pkg::CMD_DIV: begin
                den = c*c + d*d;
                if (den == 0) begin
                    r.status = cau_pkg::ST_DZ;
                end else begin
                    r.res_re = divide_part(a*c + b*d, den, sat);
                    r.res_im = divide_part(b*c - a*d, den, sat);
                end
            end
            cau_pkg::CMD_DIST: begin
                dr = a - c;
                di = b - d;
                sq = dr*dr + di*di;
                s = int_sqrt(sq);
                if (sq > s*s + s) s++;
                r.res_re = clamp_part(1'b0, s, sat);
            end
            default: ;
        endcase
        if (r.status == cau_pkg::ST_OK && sat) r.status = cau_pkg::ST_SAT;
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 31);
    endfunction

    // Offer one word, hold it until accepted, then record its expected result.
    task automatic send_word(input logic [cau_pkg::CMD_W-1:0] cmd, input logic [DW-1:0] pr,
                             input logic [DW-1:0] pi, input logic [DW-1:0] qr,
                             input logic [DW-1:0] qi);
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {qi, qr, pi, pr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        result_queue.push_back(predict_result(cmd, {qi, qr, pi, pr}));
    endtask

    function automatic logic [DW-1:0] rand_val();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(1024)) - 512);
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        logic [cau_pkg::CMD_W-1:0] cmd;
        repeat (n) begin
            // Mostly valid commands; a few unused codes.
            cmd = ($urandom_range(19) == 0) ? cau_pkg::CMD_W'($urandom_range(7, 5))
                                            : cau_pkg::CMD_W'($urandom_range(4));
            if (cmd == cau_pkg::CMD_DIV && $urandom_range(9) == 0)
                send_word(cmd, rand_val(), rand_val(), '0, '0);
            else
                send_word(cmd, rand_val(), rand_val(), rand_val(), rand_val());
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [DW-1:0] mx, mn;
        mx = 16'h7FFF;
        mn = 16'h8000;
        send_word(cau_pkg::CMD_ADD, mx, mn, mx, mn);          // saturate both ends
        send_word(cau_pkg::CMD_ADD, 16'h0100, 16'h0200, 16'hFF00, 16'h0001);
        send_word(cau_pkg::CMD_SUB, mn, mx, mx, mn);
        send_word(cau_pkg::CMD_SUB, 16'h0300, 16'h0000, 16'h0100, 16'h0080);
        send_word(cau_pkg::CMD_MUL, mn, mn, mn, mn);
        send_word(cau_pkg::CMD_MUL, 16'h0180, 16'h0080, 16'h0200, 16'hFF80); // products with no fraction to round
        send_word(cau_pkg::CMD_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
        send_word(cau_pkg::CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000); // divide by zero
        send_word(cau_pkg::CMD_DIV, mx, mx, 16'h0001, 16'h0000);
        send_word(cau_pkg::CMD_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
        send_word(cau_pkg::CMD_DIV, mn, mn, mn, mn);
        send_word(cau_pkg::CMD_DIST, 16'h0300, 16'h0400, 16'h0000, 16'h0000); // exact root
        send_word(cau_pkg::CMD_DIST, mx, mx, mn, mn);
        send_word(cau_pkg::CMD_DIST, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
        send_word(3'd5, mx, mx, mx, mx);
        send_word(3'd6, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        send_word(3'd7, mn, mn, mn, mn);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipe.
    task automatic test_backpressure();
        hold_off = 300;
        send_random(60);
        wait_drain();
    endtask

    task automatic test_random();
        send_random(800);
        no_idle = 1'b1;
        send_random(400);
        no_idle = 1'b0;
        send_random(800);
        wait_drain();
    endtask

    // Drive the receiver ready at random, with the counted hold-off.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_now();
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_cplx_result exp_r;
            if (result_queue.size() == 0) begin
                $error("unexpected result %h/%h", m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                exp_r = result_queue.pop_front();
                if (m_axis_tdata[DW-1:0] !== exp_r.res_re) begin
                    $error("res_re expected %h actual %h", exp_r.res_re, m_axis_tdata[DW-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*DW-1:DW] !== exp_r.res_im) begin
                    $error("res_im expected %h actual %h", exp_r.res_im,
                           m_axis_tdata[2*DW-1:DW]);
                    error_count++;
                end
                if (m_axis_tuser !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (LATENCY * 3) @(posedge i_clk);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
